[rtl/grg_pkg.sv]
// Shared constants, pipeline item types and the square-root constant functions.
package grg_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int F = FRACTION_BITS;
  localparam int IDX_W = 16;
  localparam int STOPS_W = 17;
  localparam int GAMMA_W = 16;
  localparam int LEVEL_W = 18;
  localparam int CFG_W = 18;
  localparam int K_W = 5;
  // Q.F mantissa in [1,2) and log2 value with integer part up to 16.
  localparam int MANT_W = F + 1;
  localparam int LOG_W = K_W + F;
  localparam int PROD_W = LOG_W + GAMMA_W;
  localparam int A_W = PROD_W - 12;
  localparam int IP_W = A_W - F;
  localparam int Y_W = MANT_W + LEVEL_W + 3;

  typedef enum logic [1:0] {
    REG_INVERSE_GAMMA = 2'd0,
    REG_CONTRAST      = 2'd1,
    REG_BRIGHTNESS    = 2'd2,
    REG_RAMP_STOPS    = 2'd3
  } cfg_reg_e;

  // Item travelling down the logarithm chain.
  typedef struct packed {
    logic              oor;
    logic              zero;
    logic [K_W-1:0]    ks;
    logic [K_W-1:0]    kn;
    logic [MANT_W-1:0] ms;
    logic [MANT_W-1:0] mn;
    logic [F-1:0]      fs;
    logic [F-1:0]      fn;
  } log_t;

  // Item travelling down the power chain.
  typedef struct packed {
    logic              oor;
    logic              zero;
    logic [IP_W-1:0]   ip;
    logic [F-1:0]      fp;
    logic [MANT_W-1:0] p;
  } exp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    x = v;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root for fraction bit k (1-based): 2^(-2^-k) in Q.F.
  function automatic logic [F-1:0] root_const(input int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << (2 * F - 1));
    for (int j = 1; j < F; j++) begin
      if (j < k) begin
        r = isqrt64(r << F);
      end
    end
    return r[F-1:0];
  endfunction

endpackage

[rtl/grg_log_cell.sv]
// One cell of the logarithm chain: produces one fraction bit of log2 for both operands.
module grg_log_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  grg_pkg::log_t item_i,
  output logic          valid_o,
  output grg_pkg::log_t item_o
);
  import grg_pkg::*;

  logic [2*MANT_W-1:0] sq_s;
  logic [2*MANT_W-1:0] sq_n;
  logic [MANT_W:0]     ms_sq;
  logic [MANT_W:0]     mn_sq;
  logic                ge_s;
  logic                ge_n;
  logic                valid_q;
  log_t                item_d;
  log_t                item_q;

  // Square each mantissa and renormalise when it reaches two.
  always_comb begin
    sq_s = item_i.ms * item_i.ms;
    sq_n = item_i.mn * item_i.mn;
    ms_sq = sq_s[F +: MANT_W+1];
    mn_sq = sq_n[F +: MANT_W+1];
    ge_s = ms_sq[MANT_W];
    ge_n = mn_sq[MANT_W];
    item_d = item_i;
    item_d.ms = ge_s ? ms_sq[MANT_W:1] : ms_sq[MANT_W-1:0];
    item_d.mn = ge_n ? mn_sq[MANT_W:1] : mn_sq[MANT_W-1:0];
    item_d.fs = {item_i.fs[F-2:0], ge_s};
    item_d.fn = {item_i.fn[F-2:0], ge_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

[rtl/grg_pow_front.sv]
// Difference of the logarithms and scaling by the exponent, two register stages.
module grg_pow_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [grg_pkg::GAMMA_W-1:0] inverse_gamma_i,
  input  logic                        valid_i,
  input  grg_pkg::log_t               item_i,
  output logic                        valid_o,
  output grg_pkg::exp_t               item_o
);
  import grg_pkg::*;

  logic [LOG_W-1:0]  ls;
  logic [LOG_W-1:0]  ln;
  logic [LOG_W-1:0]  t_d;
  logic [LOG_W-1:0]  t_q;
  logic              oor_q;
  logic              zero_q;
  logic              valid1_q;
  logic [PROD_W-1:0] prod;
  logic              valid2_q;
  exp_t              item_d;
  exp_t              item_q;

  // First stage: log2(stops) - log2(index), clamped at zero.
  always_comb begin
    ls = {item_i.ks, item_i.fs};
    ln = {item_i.kn, item_i.fn};
    t_d = (ls > ln) ? ls - ln : '0;
  end

  // Second stage: multiply by the exponent and split integer and fraction.
  always_comb begin
    prod = PROD_W'(t_q) * PROD_W'(inverse_gamma_i);
    item_d.oor = oor_q;
    item_d.zero = zero_q;
    item_d.ip = prod[PROD_W-1 -: IP_W];
    item_d.fp = prod[12 +: F];
    item_d.p = MANT_W'(1) << F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
      oor_q <= item_i.oor;
      zero_q <= item_i.zero;
      item_q <= item_d;
    end
  end

  assign valid_o = valid2_q;
  assign item_o = item_q;

endmodule

[rtl/grg_exp_cell.sv]
// One cell of the power chain: applies one fraction bit of the exponent.
module grg_exp_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [grg_pkg::F-1:0] root_i,
  input  logic                  valid_i,
  input  grg_pkg::exp_t         item_i,
  output logic                  valid_o,
  output grg_pkg::exp_t         item_o
);
  import grg_pkg::*;

  logic [MANT_W+F-1:0] prod;
  logic                valid_q;
  exp_t                item_d;
  exp_t                item_q;

  // Multiply by the root when the leading fraction bit is set, then shift it out.
  always_comb begin
    prod = (MANT_W+F)'(item_i.p) * (MANT_W+F)'(root_i);
    item_d = item_i;
    item_d.p = item_i.fp[F-1] ? prod[F +: MANT_W] : item_i.p;
    item_d.fp = {item_i.fp[F-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

[rtl/grg_output.sv]
// Level mapping, full-scale scaling and clamping, three register stages.
module grg_output (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [grg_pkg::GAMMA_W-1:0] inverse_gamma_i,
  input  logic [grg_pkg::LEVEL_W-1:0] contrast_i,
  input  logic [grg_pkg::LEVEL_W-1:0] brightness_i,
  input  logic                        valid_i,
  input  grg_pkg::exp_t               item_i,
  output logic                        valid_o,
  output logic [grg_pkg::IDX_W-1:0]   value_o,
  output logic                        oor_o
);
  import grg_pkg::*;

  localparam int SC_W = Y_W + 16;

  logic [MANT_W-1:0]        ps;
  logic signed [LEVEL_W:0]  diff;
  logic signed [Y_W-1:0]    prod_d;
  logic signed [Y_W-1:0]    prod_q;
  logic                     oor_a_q;
  logic signed [Y_W-1:0]    y_d;
  logic signed [Y_W-1:0]    y_q;
  logic                     oor_b_q;
  logic signed [SC_W-1:0]   sc;
  logic [SC_W-F-17:0]       top;
  logic [IDX_W-1:0]         value_d;
  logic [IDX_W-1:0]         value_q;
  logic                     oor_q;
  logic [2:0]               valid_q;

  // Stage A: integer shift of the power and product with the level span.
  always_comb begin
    if (item_i.zero) begin
      ps = (inverse_gamma_i == '0) ? (MANT_W'(1) << F) : '0;
    end else if (item_i.ip >= IP_W'(MANT_W)) begin
      ps = '0;
    end else begin
      ps = item_i.p >> item_i.ip;
    end
    diff = $signed({contrast_i[LEVEL_W-1], contrast_i})
         - $signed({brightness_i[LEVEL_W-1], brightness_i});
    prod_d = $signed({1'b0, ps}) * Y_W'(diff);
  end

  // Stage B: add the bottom level.
  always_comb begin
    y_d = prod_q + (Y_W'($signed(brightness_i)) <<< F);
  end

  // Stage C: scale by 0xFFFF, truncate and clamp.
  always_comb begin
    sc = (SC_W'(y_q) <<< 16) - SC_W'(y_q);
    top = sc[SC_W-1:F+16];
    if (oor_b_q || y_q <= 0) begin
      value_d = '0;
    end else if (top > (SC_W-F-16)'(16'hFFFF)) begin
      value_d = 16'hFFFF;
    end else begin
      value_d = top[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      oor_a_q <= item_i.oor;
      y_q <= y_d;
      oor_b_q <= oor_a_q;
      value_q <= value_d;
      oor_q <= oor_b_q;
    end
  end

  assign valid_o = valid_q[2];
  assign value_o = value_q;
  assign oor_o = oor_q;

endmodule

[rtl/gamma_ramp_generator.sv]
// Gamma ramp generator: accepts stop indices and returns clamped ramp entries.
//
// Input channel: in_valid_i / in_stall_o with stop_index_i; a transfer happens at a
// clock edge with valid high and stall low. Output channel: out_valid_o / out_stall_i
// with ramp_value_o and index_out_of_range_o. Configuration is written through
// cfg_we_i, cfg_index_i and cfg_data_i; the user must do so only while no item is in
// flight, as the block does not enforce this. One entry is accepted every cycle
// while the output is not stalled. A result passes one entry register, 24 cells of
// the logarithm chain (one fraction bit each), two stages for the exponent product,
// 24 cells of the power chain (one root multiply each) and three output stages.
// The whole chain advances together; it holds only while a finished result is
// stalled at the output, and then the input is stalled in the same cycle.
// Reset empties the chain and loads the default exponent 1.0, contrast 1.0,
// brightness 0 and 256 stops. An index at or above the stop count gives 0 with
// index_out_of_range_o set.
module gamma_ramp_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [grg_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [grg_pkg::IDX_W-1:0]     stop_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [grg_pkg::IDX_W-1:0]     ramp_value_o,
  output logic                          index_out_of_range_o
);
  import grg_pkg::*;

  logic [GAMMA_W-1:0] gamma_q;
  logic [LEVEL_W-1:0] contrast_q;
  logic [LEVEL_W-1:0] bright_q;
  logic [STOPS_W-1:0] stops_q;
  logic               en;
  logic [K_W-1:0]     ks;
  logic [K_W-1:0]     kn;
  log_t               entry_d;
  log_t               entry_q;
  logic               entry_valid_q;
  logic               log_valid [F+1];
  log_t               log_item [F+1];
  logic               exp_valid [F+1];
  exp_t               exp_item [F+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_W'(4096);
      contrast_q <= LEVEL_W'(65536);
      bright_q <= '0;
      stops_q <= STOPS_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INVERSE_GAMMA: gamma_q <= cfg_data_i[GAMMA_W-1:0];
        REG_CONTRAST:      contrast_q <= cfg_data_i[LEVEL_W-1:0];
        REG_BRIGHTNESS:    bright_q <= cfg_data_i[LEVEL_W-1:0];
        REG_RAMP_STOPS:    stops_q <= cfg_data_i[STOPS_W-1:0];
        default:           gamma_q <= gamma_q;
      endcase
    end
  end

  // The chain moves unless a finished result is stalled.
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Entry stage: leading-one positions and normalised mantissas.
  always_comb begin
    ks = '0;
    kn = '0;
    for (int i = 0; i < STOPS_W; i++) begin
      if (stops_q[i]) ks = K_W'(i);
    end
    for (int i = 0; i < IDX_W; i++) begin
      if (stop_index_i[i]) kn = K_W'(i);
    end
    entry_d.oor = ({1'b0, stop_index_i} >= stops_q);
    entry_d.zero = (stop_index_i == '0);
    entry_d.ks = ks;
    entry_d.kn = kn;
    entry_d.ms = MANT_W'((STOPS_W+F)'(stops_q) << (F - int'(ks)));
    entry_d.mn = MANT_W'((STOPS_W+F)'(stop_index_i) << (F - int'(kn)));
    entry_d.fs = '0;
    entry_d.fn = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (en) begin
      entry_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      entry_q <= entry_d;
    end
  end

  assign log_valid[0] = entry_valid_q;
  assign log_item[0] = entry_q;

  // Logarithm chain.
  for (genvar j = 0; j < F; j++) begin : g_log
    grg_log_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (log_valid[j]),
      .item_i  (log_item[j]),
      .valid_o (log_valid[j+1]),
      .item_o  (log_item[j+1])
    );
  end

  grg_pow_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .inverse_gamma_i (gamma_q),
    .valid_i         (log_valid[F]),
    .item_i          (log_item[F]),
    .valid_o         (exp_valid[0]),
    .item_o          (exp_item[0])
  );

  // Power chain, one constant root per cell.
  for (genvar j = 0; j < F; j++) begin : g_exp
    localparam logic [F-1:0] Root = root_const(j + 1);
    grg_exp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .root_i  (Root),
      .valid_i (exp_valid[j]),
      .item_i  (exp_item[j]),
      .valid_o (exp_valid[j+1]),
      .item_o  (exp_item[j+1])
    );
  end

  grg_output u_output (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .inverse_gamma_i (gamma_q),
    .contrast_i      (contrast_q),
    .brightness_i    (bright_q),
    .valid_i         (exp_valid[F]),
    .item_i          (exp_item[F]),
    .valid_o         (out_valid_o),
    .value_o         (ramp_value_o),
    .oor_o           (index_out_of_range_o)
  );

endmodule
